// ----- rtl/hrsa_pkg.sv -----
// ----------------------------------------------------------------------------
// hrsa_pkg
// Shared codes, widths and helpers for the halving rank slot allocator.
// ----------------------------------------------------------------------------
package hrsa_pkg;

  localparam int unsigned MaxRanksDefault = 64;
  localparam int unsigned DrainMax        = 64;
  localparam int unsigned RankW           = 6;
  localparam int unsigned SizeW           = 7;
  localparam int unsigned SlotW           = RankW + SizeW;
  localparam logic [SizeW-1:0] TotalReset = 7'd64;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_ROUND = 2'd2,
    MODE_TERM  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_SPLIT   = 3'd0,
    KIND_GRANT   = 3'd1,
    KIND_TERM    = 3'd2,
    KIND_ROUND   = 3'd3,
    KIND_FREE    = 3'd4,
    KIND_NO_SLOT = 3'd5,
    KIND_FULL    = 3'd6
  } kind_e;

  // smallest k with (v >> k) <= req
  function automatic logic [2:0] halve_shift(input logic [SizeW-1:0] v,
                                              input logic [SizeW-1:0] req);
    logic [2:0] k;
    k = 3'd7;
    for (int i = 6; i >= 0; i--) begin
      if ((v >> i) <= req) k = 3'(i);
    end
    return k;
  endfunction

endpackage

// ----- rtl/halving_rank_slot_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// halving_rank_slot_allocator_unit
// Free-slot FIFO in a synchronous memory; allocate splits by halving,
// free pushes back, round sizes a request, terminate drains the FIFO.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  request   start / busy               mode_i, rank_count_i, start_rank_i
//  result    out_strobe_o (no stall)    kind_o, target_rank_o, size_value_o,
//                                       last_o, slots_free_o, all_idle_o,
//                                       ranks_in_use_o
//  config    cfg_valid_i / cfg_ready_o  cfg_data_i (total ranks)
//
//  Free, round and error requests answer in the cycle after the transfer and
//  leave busy low. Allocate: busy through the memory read, s <= 7 halvings
//  and the grant, one result per cycle after the read. Terminate: busy while
//  n <= 64 slots drain, since the head entry is read at the transfer edge.
//  After reset and each config write, busy is high one cycle for entry 0.
//  Results cannot be stalled; each lasts exactly one cycle.
// ----------------------------------------------------------------------------
module halving_rank_slot_allocator_unit
  import hrsa_pkg::*;
#(
  parameter int unsigned MAX_RANKS = MaxRanksDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       mode_i,
  input  logic [SizeW-1:0] rank_count_i,
  input  logic [RankW-1:0] start_rank_i,
  output logic             out_strobe_o,
  output logic [2:0]       kind_o,
  output logic [RankW-1:0] target_rank_o,
  output logic [SizeW-1:0] size_value_o,
  output logic             last_o,
  output logic             slots_free_o,
  output logic             all_idle_o,
  output logic [SizeW-1:0] ranks_in_use_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [SizeW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (MAX_RANKS > 2) ? $clog2(MAX_RANKS) : 1;
  localparam int unsigned CntW = $clog2(MAX_RANKS + 1);

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_ALLOC_RD, ST_SPLIT, ST_GRANT, ST_DRAIN
  } state_e;

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] i);
    if (32'(i) + 32'd1 >= 32'(MAX_RANKS)) return '0;
    return i + 1'b1;
  endfunction

  state_e           state_q, state_d;
  logic [SizeW-1:0] total_q, total_d;
  logic [IdxW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [SizeW-1:0] used_q, used_d;
  logic [SizeW-1:0] req_q, req_d;
  logic [RankW-1:0] cur_start_q, cur_start_d;
  logic [SizeW-1:0] cur_size_q, cur_size_d;
  logic [2:0]       splits_q, splits_d;
  logic [6:0]       drain_q, drain_d;

  logic             out_strobe_q;
  logic [2:0]       kind_q;
  logic [RankW-1:0] target_q;
  logic [SizeW-1:0] size_q;
  logic             last_q, slots_free_q, all_idle_q;
  logic [SizeW-1:0] in_use_q;

  logic             emit;
  kind_e            e_kind;
  logic [RankW-1:0] e_target;
  logic [SizeW-1:0] e_size;
  logic             e_last;

  logic [SlotW-1:0] mem_q [MAX_RANKS];
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  logic [SlotW-1:0] mem_wdata;
  logic [SlotW-1:0] mem_rdata_q;

  logic [SizeW-1:0] eff_total;
  logic             accept;
  logic [RankW-1:0] rd_start;
  logic [SizeW-1:0] rd_size, fsize, lower;
  logic [2:0]       k_need, n_split;
  logic [CntW-1:0]  room;
  logic [7:0]       used_sum;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (total_q < 7'd2) begin
      eff_total = 7'd2;
    end else if (32'(total_q) > 32'(MAX_RANKS)) begin
      eff_total = SizeW'(MAX_RANKS);
    end else begin
      eff_total = total_q;
    end
  end

  assign rd_start = mem_rdata_q[SlotW-1:SizeW];
  assign rd_size  = mem_rdata_q[SizeW-1:0];
  assign k_need   = halve_shift(rd_size, req_q);
  assign room     = CntW'(MAX_RANKS) - count_q;
  assign n_split  = (32'(room) < 32'(k_need)) ? 3'(room) : k_need;
  assign fsize    = rd_size >> n_split;
  assign used_sum = {1'b0, used_q} + {1'b0, fsize};
  assign lower    = cur_size_q >> 1;

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    used_d      = used_q;
    req_d       = req_q;
    cur_start_d = cur_start_q;
    cur_size_d  = cur_size_q;
    splits_d    = splits_q;
    drain_d     = drain_q;
    emit        = 1'b0;
    e_kind      = KIND_SPLIT;
    e_target    = '0;
    e_size      = '0;
    e_last      = 1'b1;
    mem_we      = 1'b0;
    mem_waddr   = tail_q;
    mem_wdata   = '0;

    unique case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = {RankW'(0), eff_total - 7'd1};
        state_d   = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (mode_e'(mode_i))
            MODE_ALLOC: begin
              if (count_q == '0) begin
                emit   = 1'b1;
                e_kind = KIND_NO_SLOT;
              end else begin
                head_d  = next_idx(head_q);
                count_d = count_q - 1'b1;
                req_d   = rank_count_i;
                state_d = ST_ALLOC_RD;
              end
            end
            MODE_FREE: begin
              emit = 1'b1;
              if (32'(count_q) >= 32'(MAX_RANKS)) begin
                e_kind = KIND_FULL;
              end else begin
                used_d    = (rank_count_i > used_q) ? '0 : used_q - rank_count_i;
                mem_we    = 1'b1;
                mem_wdata = {start_rank_i, rank_count_i};
                tail_d    = next_idx(tail_q);
                count_d   = count_q + 1'b1;
                e_kind    = KIND_FREE;
                e_target  = start_rank_i;
                e_size    = rank_count_i;
              end
            end
            MODE_ROUND: begin
              emit   = 1'b1;
              e_kind = KIND_ROUND;
              e_size = eff_total >> halve_shift(eff_total, rank_count_i);
            end
            MODE_TERM: begin
              if (count_q != '0) begin
                head_d  = next_idx(head_q);
                state_d = ST_DRAIN;
                if (32'(count_q) > 32'(DrainMax)) begin
                  drain_d = 7'(DrainMax);
                  count_d = count_q - CntW'(DrainMax);
                end else begin
                  drain_d = 7'(count_q);
                  count_d = '0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_ALLOC_RD: begin
        cur_start_d = rd_start;
        cur_size_d  = rd_size;
        splits_d    = n_split;
        count_d     = count_q + CntW'(n_split);
        used_d      = used_sum[7] ? 7'd127 : used_sum[6:0];
        state_d     = (n_split != 3'd0) ? ST_SPLIT : ST_GRANT;
      end
      ST_SPLIT: begin
        emit        = 1'b1;
        e_kind      = KIND_SPLIT;
        e_target    = cur_start_q;
        e_size      = lower;
        e_last      = 1'b0;
        mem_we      = 1'b1;
        mem_wdata   = {cur_start_q + lower[RankW-1:0], cur_size_q - lower};
        tail_d      = next_idx(tail_q);
        cur_size_d  = lower;
        splits_d    = splits_q - 3'd1;
        if (splits_q == 3'd1) state_d = ST_GRANT;
      end
      ST_GRANT: begin
        emit     = 1'b1;
        e_kind   = KIND_GRANT;
        e_target = cur_start_q;
        e_size   = cur_size_q;
        state_d  = ST_IDLE;
      end
      ST_DRAIN: begin
        emit     = 1'b1;
        e_kind   = KIND_TERM;
        e_target = rd_start;
        e_size   = rd_size;
        e_last   = (drain_q == 7'd1);
        drain_d  = drain_q - 7'd1;
        if (drain_q == 7'd1) begin
          state_d = ST_IDLE;
        end else begin
          head_d = next_idx(head_q);
        end
      end
      default: state_d = ST_INIT;
    endcase

    if (cfg_valid_i) begin
      total_d = cfg_data_i;
      head_d  = '0;
      tail_d  = IdxW'(1);
      count_d = CntW'(1);
      used_d  = '0;
      state_d = ST_INIT;
      emit    = 1'b0;
      mem_we  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      total_q      <= TotalReset;
      head_q       <= '0;
      tail_q       <= IdxW'(1);
      count_q      <= CntW'(1);
      used_q       <= '0;
      req_q        <= '0;
      cur_start_q  <= '0;
      cur_size_q   <= '0;
      splits_q     <= '0;
      drain_q      <= '0;
      out_strobe_q <= 1'b0;
      kind_q       <= '0;
      target_q     <= '0;
      size_q       <= '0;
      last_q       <= 1'b0;
      slots_free_q <= 1'b0;
      all_idle_q   <= 1'b0;
      in_use_q     <= '0;
    end else begin
      state_q      <= state_d;
      total_q      <= total_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      used_q       <= used_d;
      req_q        <= req_d;
      cur_start_q  <= cur_start_d;
      cur_size_q   <= cur_size_d;
      splits_q     <= splits_d;
      drain_q      <= drain_d;
      out_strobe_q <= emit;
      if (emit) begin
        kind_q       <= e_kind;
        target_q     <= e_target;
        size_q       <= e_size;
        last_q       <= e_last;
        slots_free_q <= (count_d != '0);
        all_idle_q   <= (used_d == '0);
        in_use_q     <= used_d;
      end
    end
  end

  // slot memory: one write port, one read port at the queue head
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    mem_rdata_q <= mem_q[head_q];
  end

  assign out_strobe_o   = out_strobe_q;
  assign kind_o         = kind_q;
  assign target_rank_o  = target_q;
  assign size_value_o   = size_q;
  assign last_o         = last_q;
  assign slots_free_o   = slots_free_q;
  assign all_idle_o     = all_idle_q;
  assign ranks_in_use_o = in_use_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(MAX_RANKS))
    else $error("free slot count exceeds queue depth");

  a_split_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && (kind_o == KIND_SPLIT) |-> !last_o)
    else $error("split order marked as last result");

  a_round_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (mode_i == MODE_ROUND) && !cfg_valid_i |=> out_strobe_o && last_o)
    else $error("round request not answered in the next cycle");

  a_split_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SPLIT) |-> (splits_q != 3'd0))
    else $error("split state with no halvings left");
`endif

endmodule

// ----- tb/halving_rank_slot_allocator_unit_test.sv -----
// ----------------------------------------------------------------------------
// halving_rank_slot_allocator_unit_test
// Self-checking bench for the halving rank slot allocator. A tracker class
// keeps its own free-slot FIFO and in-use count. It predicts every split
// order, grant, drain signal, rounded size, free ack and error result of
// each accepted request. Observed results are compared in order. The run
// starts with directed corner cases and then goes through random phases
// under several total-rank settings and sender idle rates, with one phase
// that fills the slot FIFO.
// ----------------------------------------------------------------------------
module halving_rank_slot_allocator_unit_test;
  import hrsa_pkg::*;

  localparam int unsigned QueueDepth = MaxRanksDefault;

  typedef struct packed {
    logic [RankW-1:0] first_rank;
    logic [SizeW-1:0] rank_span;
  } slot_t;

  typedef struct packed {
    kind_e            kind;
    logic [RankW-1:0] target_rank;
    logic [SizeW-1:0] size_value;
    logic             last;
    logic             slots_free;
    logic             all_idle;
    logic [SizeW-1:0] ranks_in_use;
  } slot_result_t;

  class rank_slot_tracker;
    slot_t            free_ring [QueueDepth];
    int unsigned      ring_head;
    int unsigned      ring_tail;
    int unsigned      ring_count;
    int unsigned      used_ranks;
    logic [SizeW-1:0] total_reg;
    slot_result_t     pending_results [$];
    slot_t            granted_slots [$];
    int unsigned      mismatch_count;
    int unsigned      results_seen;

    function new();
      mismatch_count = 0;
      results_seen   = 0;
      restart(TotalReset);
    endfunction

    function int unsigned eff_total();
      int unsigned t;
      t = total_reg;
      if (t < 2) t = 2;
      if (t > QueueDepth) t = QueueDepth;
      return t;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void push_slot(input int unsigned first, input int unsigned span);
      free_ring[ring_tail].first_rank = RankW'(first);
      free_ring[ring_tail].rank_span  = SizeW'(span);
      ring_tail = (ring_tail + 1) % QueueDepth;
      ring_count++;
    endfunction

    function slot_t pop_slot();
      slot_t s;
      s = free_ring[ring_head];
      ring_head = (ring_head + 1) % QueueDepth;
      ring_count--;
      return s;
    endfunction

    function void restart(input logic [SizeW-1:0] value);
      total_reg = value;
      foreach (free_ring[i]) free_ring[i] = '0;
      ring_head  = 0;
      ring_tail  = 0;
      ring_count = 0;
      used_ranks = 0;
      granted_slots.delete();
      push_slot(0, eff_total() - 1);
    endfunction

    function slot_result_t make_entry(input kind_e k, input int unsigned target,
                                      input int unsigned span);
      slot_result_t e;
      e              = '0;
      e.kind         = k;
      e.target_rank  = RankW'(target);
      e.size_value   = SizeW'(span);
      return e;
    endfunction

    function void note_request(input mode_e m, input logic [SizeW-1:0] req,
                               input logic [RankW-1:0] srank);
      slot_result_t batch [$];
      slot_t        cur;
      int unsigned  lower;
      int unsigned  v;
      case (m)
        MODE_ALLOC: begin
          if (ring_count == 0) begin
            batch.insert(batch.size(), make_entry(KIND_NO_SLOT, 0, 0));
          end else begin
            cur = pop_slot();
            while (cur.rank_span > req && ring_count < QueueDepth) begin
              lower = cur.rank_span / 2;
              batch.insert(batch.size(), make_entry(KIND_SPLIT, cur.first_rank, lower));
              push_slot(cur.first_rank + lower, cur.rank_span - lower);
              cur.rank_span = SizeW'(lower);
            end
            used_ranks += cur.rank_span;
            if (used_ranks > 127) used_ranks = 127;
            batch.insert(batch.size(),
                         make_entry(KIND_GRANT, cur.first_rank, cur.rank_span));
            granted_slots.insert(granted_slots.size(), cur);
          end
        end
        MODE_FREE: begin
          if (ring_count >= QueueDepth) begin
            batch.insert(batch.size(), make_entry(KIND_FULL, 0, 0));
          end else begin
            used_ranks = (req > used_ranks) ? 0 : used_ranks - req;
            push_slot(srank, req);
            batch.insert(batch.size(), make_entry(KIND_FREE, srank, req));
          end
        end
        MODE_ROUND: begin
          v = eff_total();
          while (v > req) v = v / 2;
          batch.insert(batch.size(), make_entry(KIND_ROUND, 0, v));
        end
        default: begin
          while (ring_count > 0 && batch.size() < DrainMax) begin
            cur = pop_slot();
            batch.insert(batch.size(),
                         make_entry(KIND_TERM, cur.first_rank, cur.rank_span));
          end
        end
      endcase
      foreach (batch[i]) begin
        batch[i].last         = (i == batch.size() - 1);
        batch[i].slots_free   = (ring_count != 0);
        batch[i].all_idle     = (used_ranks == 0);
        batch[i].ranks_in_use = SizeW'(used_ranks);
        pending_results.insert(pending_results.size(), batch[i]);
      end
    endfunction

    task report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_result(input slot_result_t got);
      slot_result_t exp;
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected (kind %0d)",
                                  results_seen, got.kind));
      end else begin
        exp = pending_results.pop_front();
        if (got.kind !== exp.kind)
          report_mismatch($sformatf("result %0d kind %0d, expected %0d",
                                    results_seen, got.kind, exp.kind));
        if (got.target_rank !== exp.target_rank)
          report_mismatch($sformatf("result %0d target_rank %0d, expected %0d",
                                    results_seen, got.target_rank, exp.target_rank));
        if (got.size_value !== exp.size_value)
          report_mismatch($sformatf("result %0d size_value %0d, expected %0d",
                                    results_seen, got.size_value, exp.size_value));
        if (got.last !== exp.last)
          report_mismatch($sformatf("result %0d last %b, expected %b",
                                    results_seen, got.last, exp.last));
        if (got.slots_free !== exp.slots_free)
          report_mismatch($sformatf("result %0d slots_free %b, expected %b",
                                    results_seen, got.slots_free, exp.slots_free));
        if (got.all_idle !== exp.all_idle)
          report_mismatch($sformatf("result %0d all_idle %b, expected %b",
                                    results_seen, got.all_idle, exp.all_idle));
        if (got.ranks_in_use !== exp.ranks_in_use)
          report_mismatch($sformatf("result %0d ranks_in_use %0d, expected %0d",
                                    results_seen, got.ranks_in_use, exp.ranks_in_use));
      end
    endtask
  endclass

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             start          = 1'b0;
  logic             busy;
  logic [1:0]       mode_i         = MODE_ALLOC;
  logic [SizeW-1:0] rank_count_i   = '0;
  logic [RankW-1:0] start_rank_i   = '0;
  logic             out_strobe_o;
  logic [2:0]       kind_o;
  logic [RankW-1:0] target_rank_o;
  logic [SizeW-1:0] size_value_o;
  logic             last_o;
  logic             slots_free_o;
  logic             all_idle_o;
  logic [SizeW-1:0] ranks_in_use_o;
  logic             cfg_valid_i    = 1'b0;
  logic             cfg_ready_o;
  logic [SizeW-1:0] cfg_data_i     = '0;

  rank_slot_tracker slot_tracker;
  int unsigned      idle_pct = 0;

  halving_rank_slot_allocator_unit i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin : monitor
    slot_result_t seen;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) slot_tracker.restart(cfg_data_i);
      if (start && !busy) slot_tracker.note_request(mode_e'(mode_i), rank_count_i,
                                                    start_rank_i);
      if (out_strobe_o) begin
        seen.kind         = kind_e'(kind_o);
        seen.target_rank  = target_rank_o;
        seen.size_value   = size_value_o;
        seen.last         = last_o;
        seen.slots_free   = slots_free_o;
        seen.all_idle     = all_idle_o;
        seen.ranks_in_use = ranks_in_use_o;
        slot_tracker.check_result(seen);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("** halving_rank_slot_allocator_unit: FAILED **");
    $finish;
  end

  // returns at the rising edge that takes the transfer
  task automatic send_req(input mode_e m, input int unsigned cnt,
                          input int unsigned srank);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start        <= 1'b1;
    mode_i       <= m;
    rank_count_i <= SizeW'(cnt);
    start_rank_i <= RankW'(srank);
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (slot_tracker.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_total(input int unsigned v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= SizeW'(v);
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int unsigned pick_count(input int unsigned total);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 25) return $urandom_range(127);
    if (r < 55) return total >> $urandom_range(6);
    return $urandom_range(total, 1);
  endfunction

  task automatic random_item();
    int unsigned r;
    int unsigned pick;
    slot_t       s;
    r = $urandom_range(99);
    if (r < 40) begin
      send_req(MODE_ALLOC, pick_count(slot_tracker.eff_total()), $urandom_range(63));
    end else if (r < 70) begin
      if (slot_tracker.granted_slots.size() != 0 && $urandom_range(4) != 0) begin
        pick = $urandom_range(slot_tracker.granted_slots.size() - 1);
        s = slot_tracker.granted_slots[pick];
        slot_tracker.granted_slots.delete(pick);
        send_req(MODE_FREE, s.rank_span, s.first_rank);
      end else begin
        send_req(MODE_FREE, $urandom_range(127), $urandom_range(63));
      end
    end else if (r < 92) begin
      send_req(MODE_ROUND, $urandom_range(127), $urandom_range(63));
    end else begin
      send_req(MODE_TERM, $urandom_range(127), $urandom_range(63));
    end
  endtask

  task automatic run_phase(input int unsigned total, input int unsigned pct,
                           input int unsigned n_items);
    settle();
    write_total(total);
    idle_pct = pct;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) settle();
      random_item();
    end
    settle();
  endtask

  task automatic directed_items();
    send_req(MODE_ROUND, 0, 0);
    send_req(MODE_ROUND, 64, 63);
    send_req(MODE_ROUND, 127, 0);
    send_req(MODE_ROUND, 33, 0);
    send_req(MODE_ALLOC, 1, 0);
    send_req(MODE_ALLOC, 0, 63);
    send_req(MODE_FREE, 127, 63);
    send_req(MODE_FREE, 0, 0);
    send_req(MODE_ALLOC, 127, 0);
    send_req(MODE_TERM, 0, 0);
    send_req(MODE_TERM, 127, 63);
    send_req(MODE_ALLOC, 5, 0);
    // split past rank 63 wraps the start
    send_req(MODE_FREE, 8, 62);
    send_req(MODE_ALLOC, 1, 0);
    send_req(MODE_TERM, 0, 0);
    // in-use count reaches its 127 maximum, then clamps at zero
    send_req(MODE_FREE, 127, 0);
    send_req(MODE_ALLOC, 127, 0);
    send_req(MODE_FREE, 127, 1);
    send_req(MODE_ALLOC, 127, 0);
    send_req(MODE_FREE, 127, 2);
    send_req(MODE_FREE, 5, 3);
    send_req(MODE_ROUND, 1, 0);
  endtask

  initial begin
    int unsigned waited;
    slot_tracker = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_items();
    settle();

    run_phase(127, 0, 24);
    run_phase(2, 78, 24);
    run_phase($urandom_range(63, 3), 11, 24);
    run_phase(0, 78, 24);

    // fill the slot FIFO, then hit the full cases and a maximal drain
    write_total(1);
    settle();
    write_total(64);
    idle_pct = 11;
    for (int i = 0; i < 65; i++) send_req(MODE_FREE, $urandom_range(8, 1), $urandom_range(63));
    send_req(MODE_ALLOC, 0, 0);
    send_req(MODE_TERM, 0, 0);
    send_req(MODE_TERM, 0, 0);
    send_req(MODE_ALLOC, 1, 0);
    settle();

    run_phase(64, 0, 24);

    start <= 1'b0;
    waited = 0;
    while (slot_tracker.pending() != 0 && waited < 500) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (80) @(negedge clk_i);
    if (slot_tracker.pending() != 0)
      slot_tracker.report_mismatch($sformatf("%0d expected results never arrived",
                                             slot_tracker.pending()));
    if (slot_tracker.mismatch_count == 0) begin
      $display("** halving_rank_slot_allocator_unit: PASSED **");
    end else begin
      $display("** halving_rank_slot_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule
